// ===== rtl/core/napt_translation_table_top_assert.svh =====
// Assertion helpers for the RTL; napt_back includes them.
// Both macros expect clk and rst_n to be in scope at the point of use.
`ifndef NAPT_TRANSLATION_TABLE_TOP_ASSERT_SVH
`define NAPT_TRANSLATION_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define NAPT_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define NAPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/napt_pkg.sv =====
package napt_pkg;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int TTL_W     = 8;
    localparam int PROTO_W   = 8;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 1;

    // Opcodes and protocol numbers
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_PACKET = 1'b1;
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAN_ADDRESS        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_LAN_ADDRESS = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PASS   = 3'd0,
        ACT_OUT    = 3'd1,
        ACT_IN     = 3'd2,
        ACT_TTL    = 3'd3,
        ACT_DROP   = 3'd4,
        ACT_LOADED = 3'd5,
        ACT_FULL   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_TTL,
        CMD_PASS,
        CMD_LOOKUP
    } cmd_kind_t;

    // Classified item; a load carries its entry in src / sport / dport
    typedef struct packed {
        cmd_kind_t           kind;
        logic [TTL_W-1:0]    ttl;
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [PORT_W-1:0]   sport;
        logic [PORT_W-1:0]   dport;
        logic                dst_is_wan;
        logic                lan_side;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lan_addr;
        logic [PORT_W-1:0] priv_port;
        logic [PORT_W-1:0] pub_port;
    } entry_t;

    typedef struct packed {
        action_t           action;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PORT_W-1:0] sport;
        logic [PORT_W-1:0] dport;
        logic [TTL_W-1:0]  ttl;
        logic              added;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } back_state_t;

    // Classful network number of an IPv4 address
    function automatic logic [ADDR_W-1:0] class_net(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] net;
        if (a[31] == 1'b0)
            net = {24'd0, a[31:24]};
        else if (a[31:30] == 2'b10)
            net = {16'd0, a[31:16]};
        else if (a[31:29] == 3'b110)
            net = {8'd0, a[31:8]};
        else
            net = a;
        return net;
    endfunction

endpackage

// ===== rtl/core/napt_if.sv =====
// Request channel: one load or packet header per transfer
interface napt_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [napt_pkg::PROTO_W-1:0] protocol;
    logic [napt_pkg::TTL_W-1:0]   ttl_in;
    logic [napt_pkg::ADDR_W-1:0]  source_address;
    logic [napt_pkg::ADDR_W-1:0]  dest_address;
    logic [napt_pkg::PORT_W-1:0]  source_port;
    logic [napt_pkg::PORT_W-1:0]  dest_port;
    logic [napt_pkg::ADDR_W-1:0]  load_lan_address;
    logic [napt_pkg::PORT_W-1:0]  load_lan_port;
    logic [napt_pkg::PORT_W-1:0]  load_wan_port;

    modport source (
        output valid, opcode, protocol, ttl_in, source_address, dest_address,
               source_port, dest_port, load_lan_address, load_lan_port, load_wan_port,
        input  ready
    );
    modport sink (
        input  valid, opcode, protocol, ttl_in, source_address, dest_address,
               source_port, dest_port, load_lan_address, load_lan_port, load_wan_port,
        output ready
    );
endinterface

// Response channel: one result per request
interface napt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [napt_pkg::ACT_W-1:0]  action;
    logic [napt_pkg::ADDR_W-1:0] out_source_address;
    logic [napt_pkg::ADDR_W-1:0] out_dest_address;
    logic [napt_pkg::PORT_W-1:0] out_source_port;
    logic [napt_pkg::PORT_W-1:0] out_dest_port;
    logic [napt_pkg::TTL_W-1:0]  ttl_out;
    logic                        dynamic_added;

    modport source (
        output valid, action, out_source_address, out_dest_address,
               out_source_port, out_dest_port, ttl_out, dynamic_added,
        input  ready
    );
    modport sink (
        input  valid, action, out_source_address, out_dest_address,
               out_source_port, out_dest_port, ttl_out, dynamic_added,
        output ready
    );
endinterface

// Configuration write channel
interface napt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [napt_pkg::CFG_IDX_W-1:0] index;
    logic [napt_pkg::ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/napt_ram.sv =====
module napt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/napt_front.sv =====
module napt_front (
    napt_req_if.sink                    req,
    input  logic [napt_pkg::ADDR_W-1:0] wan_address,
    input  logic [napt_pkg::ADDR_W-1:0] router_lan_address,
    input  logic                        queue_full,
    output logic                        push,
    output napt_pkg::cmd_t              cmd
);
    import napt_pkg::*;

    logic ttl_ok;
    logic tcp_udp;
    logic cross_net;

    // Take a request whenever the queue has a free slot
    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;

    assign ttl_ok    = req.ttl_in > TTL_W'(1);
    assign tcp_udp   = (req.protocol == PROTO_TCP) || (req.protocol == PROTO_UDP);
    assign cross_net = class_net(req.source_address) != class_net(req.dest_address);

    // Classify and pack the command
    always_comb
    begin
        cmd            = '0;
        cmd.ttl        = req.ttl_in - TTL_W'(1);
        cmd.dst        = req.dest_address;
        cmd.dst_is_wan = req.dest_address == wan_address;
        cmd.lan_side   = class_net(req.source_address) == class_net(router_lan_address);
        if (req.opcode == OP_LOAD)
        begin
            cmd.kind  = CMD_LOAD;
            cmd.src   = req.load_lan_address;
            cmd.sport = req.load_lan_port;
            cmd.dport = req.load_wan_port;
        end
        else
        begin
            cmd.src   = req.source_address;
            cmd.sport = req.source_port;
            cmd.dport = req.dest_port;
            if (!ttl_ok)
                cmd.kind = CMD_TTL;
            else if (tcp_udp && cross_net)
                cmd.kind = CMD_LOOKUP;
            else
                cmd.kind = CMD_PASS;
        end
    end

endmodule

// ===== rtl/core/napt_queue.sv =====
module napt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  napt_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output napt_pkg::cmd_t head_cmd
);
    import napt_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign full       = fill_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/napt_back.sv =====
`include "napt_translation_table_top_assert.svh"

module napt_back #(
    parameter int TABLE_DEPTH       = 32,
    parameter int DYNAMIC_PORT_BASE = 49152
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [napt_pkg::ADDR_W-1:0] wan_address,
    input  logic                        cmd_valid,
    input  napt_pkg::cmd_t              cmd_in,
    output logic                        cmd_pop,
    napt_rsp_if.source                  rsp
);
    import napt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  dyn_reg, dyn_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              known_reg, known_next;
    logic              hit_reg, hit_next;
    logic              hit_in_reg, hit_in_next;
    entry_t            hit_entry_reg, hit_entry_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg;
    result_t           res_val;

    logic              room;
    logic              walk_issue;
    logic              walk_done;
    logic              slot_free;
    logic              emit;
    logic              load_ok;
    logic              ins;
    logic [PORT_W-1:0] new_wport;
    logic              ram_we;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    logic              src_m;
    logic              port_m;
    logic              in_m;

    // Entry table
    napt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Status terms
    assign room       = count_reg < CNT_W'(TABLE_DEPTH);
    assign walk_issue = (state_reg == ST_WALK) && (rd_idx_reg < count_reg);
    assign walk_done  = (state_reg == ST_WALK) && !walk_issue && !rd_pend_reg;
    assign slot_free  = !res_valid_reg || rsp.ready;
    assign load_ok    = (cmd_reg.kind == CMD_LOAD) && room;
    assign ins        = (cmd_reg.kind == CMD_LOOKUP) && !known_reg && cmd_reg.lan_side && room;
    assign new_wport  = PORT_W'(DYNAMIC_PORT_BASE) + PORT_W'(dyn_reg);

    // Entry compare on the word coming back from the table
    assign src_m  = ram_rdata.lan_addr == cmd_reg.src;
    assign port_m = ram_rdata.priv_port == cmd_reg.sport;
    assign in_m   = cmd_reg.dst_is_wan && (ram_rdata.pub_port == cmd_reg.dport);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = (cmd_in.kind == CMD_LOOKUP) ? ST_WALK : ST_EMIT;
            end
            ST_WALK:
            begin
                if (walk_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_pop = cmd_valid;
            ST_WALK: ;
            ST_EMIT: emit = slot_free;
            default: ;
        endcase
    end

    // Table write for a load or a dynamic insert
    assign ram_we              = emit && (load_ok || ins);
    assign ram_wdata.lan_addr  = cmd_reg.src;
    assign ram_wdata.priv_port = cmd_reg.sport;
    assign ram_wdata.pub_port  = load_ok ? cmd_reg.dport : new_wport;

    // Walk bookkeeping: first hit wins, exact match tracked over all entries
    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = walk_issue;
        known_next     = known_reg;
        hit_next       = hit_reg;
        hit_in_next    = hit_in_reg;
        hit_entry_next = hit_entry_reg;
        if (cmd_pop)
        begin
            rd_idx_next = '0;
            known_next  = 1'b0;
            hit_next    = 1'b0;
        end
        else
        begin
            if (walk_issue)
                rd_idx_next = rd_idx_reg + 1'b1;
            if (rd_pend_reg)
            begin
                if (src_m && port_m)
                    known_next = 1'b1;
                if (!hit_reg)
                begin
                    if (src_m && port_m)
                    begin
                        hit_next       = 1'b1;
                        hit_in_next    = 1'b0;
                        hit_entry_next = ram_rdata;
                    end
                    else if (!src_m && in_m)
                    begin
                        hit_next       = 1'b1;
                        hit_in_next    = 1'b1;
                        hit_entry_next = ram_rdata;
                    end
                end
            end
        end
    end

    // Result of the current command
    always_comb
    begin
        res_val = '0;
        case (cmd_reg.kind)
            CMD_LOAD:
            begin
                res_val.action = room ? ACT_LOADED : ACT_FULL;
            end
            CMD_TTL:
            begin
                res_val.action = ACT_TTL;
            end
            CMD_PASS:
            begin
                res_val.action = ACT_PASS;
                res_val.src    = cmd_reg.src;
                res_val.dst    = cmd_reg.dst;
                res_val.sport  = cmd_reg.sport;
                res_val.dport  = cmd_reg.dport;
                res_val.ttl    = cmd_reg.ttl;
            end
            CMD_LOOKUP:
            begin
                res_val.action = ACT_DROP;
                res_val.src    = cmd_reg.src;
                res_val.dst    = cmd_reg.dst;
                res_val.sport  = cmd_reg.sport;
                res_val.dport  = cmd_reg.dport;
                res_val.ttl    = cmd_reg.ttl;
                res_val.added  = ins;
                if (hit_reg && hit_in_reg)
                begin
                    res_val.action = ACT_IN;
                    res_val.dst    = hit_entry_reg.lan_addr;
                    res_val.dport  = hit_entry_reg.priv_port;
                end
                else if (hit_reg)
                begin
                    res_val.action = ACT_OUT;
                    res_val.src    = wan_address;
                    res_val.sport  = hit_entry_reg.pub_port;
                end
                else if (ins)
                begin
                    // New entry is the first match of the walk
                    res_val.action = ACT_OUT;
                    res_val.src    = wan_address;
                    res_val.sport  = new_wport;
                end
            end
            default: res_val = '0;
        endcase
    end

    // Counters and output slot
    always_comb
    begin
        count_next     = count_reg;
        dyn_next       = dyn_reg;
        res_valid_next = res_valid_reg;
        if (ram_we)
            count_next = count_reg + 1'b1;
        if (emit && ins)
            dyn_next = dyn_reg + 1'b1;
        if (emit)
            res_valid_next = 1'b1;
        else if (rsp.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dyn_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            known_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dyn_reg       <= dyn_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            known_reg     <= known_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd_in;
        hit_in_reg    <= hit_in_next;
        hit_entry_reg <= hit_entry_next;
        if (emit)
            res_reg <= res_val;
    end

    assign rsp.valid              = res_valid_reg;
    assign rsp.action             = res_reg.action;
    assign rsp.out_source_address = res_reg.src;
    assign rsp.out_dest_address   = res_reg.dst;
    assign rsp.out_source_port    = res_reg.sport;
    assign rsp.out_dest_port      = res_reg.dport;
    assign rsp.ttl_out            = res_reg.ttl;
    assign rsp.dynamic_added      = res_reg.added;

    `NAPT_ASSERT(count_bound_a, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "table overfilled")
    `NAPT_ASSERT(dyn_bound_a, 1'b1, dyn_reg <= count_reg, "more dynamic entries than entries")
    `NAPT_ASSERT(walk_idx_a, state_reg == ST_WALK, rd_idx_reg <= count_reg, "walk past table end")
    `NAPT_ASSERT_NEXT(insert_count_a, ram_we, count_reg == $past(count_reg) + 1'b1, "write without count step")
    `NAPT_ASSERT_NEXT(emit_slot_a, emit, res_valid_reg && (state_reg == ST_IDLE), "emitted result lost")

endmodule

// ===== rtl/core/napt_translation_table_top.sv =====
// NAPT translation table.
// req carries one item per transfer: a static entry load (opcode 0) or a
// packet header (opcode 1). rsp returns exactly one result per request, in
// order. cfg writes wan_address (index 0) and router_lan_address (index 1);
// it is always ready. The user must write cfg only while the block is idle;
// the block itself does not enforce this. The front classifies each request
// (load, TTL drop, pass, table lookup) into a two-entry command queue; the
// back executes commands one at a time. Loads, TTL drops and passes are popped
// in the idle state and answered in the emit state; a lookup walks the table in
// between, issuing one table read per entry to a RAM with registered read and
// taking in the last read word before the emit state.
// Reset empties the queue and the result slot and sets both entry counters to
// zero; table contents need no clearing. When rsp stalls, the result stays in
// its output register, the back finishes one more command and waits, and req
// keeps taking transfers until the queue is full.
module napt_translation_table_top #(
    parameter int TABLE_DEPTH       = 32,
    parameter int DYNAMIC_PORT_BASE = 49152
) (
    input  logic       clk,
    input  logic       rst_n,
    napt_req_if.sink   req,
    napt_rsp_if.source rsp,
    napt_cfg_if.sink   cfg
);
    import napt_pkg::*;

    logic [ADDR_W-1:0] wan_reg;
    logic [ADDR_W-1:0] lan_reg;
    logic              push;
    cmd_t              push_cmd;
    logic              queue_full;
    logic              head_valid;
    cmd_t              head_cmd;
    logic              pop;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wan_reg <= '0;
            lan_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WAN_ADDRESS:        wan_reg <= cfg.data;
                CFG_ROUTER_LAN_ADDRESS: lan_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    napt_front u_front (
        .req                (req),
        .wan_address        (wan_reg),
        .router_lan_address (lan_reg),
        .queue_full         (queue_full),
        .push               (push),
        .cmd                (push_cmd)
    );

    napt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    napt_back #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .DYNAMIC_PORT_BASE (DYNAMIC_PORT_BASE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wan_address (wan_reg),
        .cmd_valid   (head_valid),
        .cmd_in      (head_cmd),
        .cmd_pop     (pop),
        .rsp         (rsp)
    );

endmodule

// ===== tb/tb_napt_translation_table_top.sv =====
`timescale 1ns / 1ps

module tb_napt_translation_table_top;
    import napt_pkg::*;

    localparam int TABLE_DEPTH       = 32;
    localparam int DYNAMIC_PORT_BASE = 49152;
    // Worst quiet stretch: a full-table walk, the longest receiver stall, a
    // queued second command and a sender gap, all well under this many cycles
    // without a transfer.
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES      = 40;

    typedef struct {
        logic              opcode;
        logic [PROTO_W-1:0] protocol;
        logic [TTL_W-1:0]  ttl_in;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [ADDR_W-1:0] ld_addr;
        logic [PORT_W-1:0] ld_priv_port;
        logic [PORT_W-1:0] ld_pub_port;
    } napt_item_t;

    logic clk;
    logic rst_n;

    napt_req_if req ();
    napt_rsp_if rsp ();
    napt_cfg_if cfg ();

    napt_translation_table_top #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .DYNAMIC_PORT_BASE (DYNAMIC_PORT_BASE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Predicted translation table and registers
    logic [ADDR_W-1:0] tbl_lan_addr [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_priv_port [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_pub_port [TABLE_DEPTH];
    int                tbl_used;
    int                dyn_created;
    logic [ADDR_W-1:0] reg_wan_addr;
    logic [ADDR_W-1:0] reg_router_lan;

    result_t pending_results [$];
    int      err_count;
    int      burst_left;
    int      idle_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Network part of an address under classful rules
    function automatic logic [ADDR_W-1:0] classful_prefix(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] p;
        if (!a[31])
            p = a >> 24;
        else if (a[31:30] == 2'b10)
            p = a >> 16;
        else if (a[31:29] == 3'b110)
            p = a >> 8;
        else
            p = a;
        return p;
    endfunction

    function automatic bit append_entry(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] lp,
                                        input logic [PORT_W-1:0] wp);
        if (tbl_used >= TABLE_DEPTH)
            return 1'b0;
        tbl_lan_addr[tbl_used] = a;
        tbl_priv_port[tbl_used] = lp;
        tbl_pub_port[tbl_used] = wp;
        tbl_used++;
        return 1'b1;
    endfunction

    // Expected result of one accepted item; updates the predicted table
    function automatic result_t predict_translation(input napt_item_t it);
        result_t           r;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] d;
        logic [PORT_W-1:0] sp;
        logic [PORT_W-1:0] dp;
        bit                known;
        bit                hit;
        r = '0;
        if (it.opcode == OP_LOAD)
        begin
            r.action = append_entry(it.ld_addr, it.ld_priv_port, it.ld_pub_port) ?
                       ACT_LOADED : ACT_FULL;
            return r;
        end
        if (it.ttl_in <= 8'd1)
        begin
            r.action = ACT_TTL;
            return r;
        end
        s = it.src_addr;
        d = it.dst_addr;
        sp = it.src_port;
        dp = it.dst_port;
        r.action = ACT_PASS;
        if ((it.protocol == PROTO_TCP || it.protocol == PROTO_UDP) &&
            classful_prefix(s) != classful_prefix(d))
        begin
            known = 1'b0;
            for (int i = 0; i < tbl_used; i++)
                if (tbl_lan_addr[i] == s && tbl_priv_port[i] == sp)
                    known = 1'b1;
            // New LAN flow gets a dynamic WAN port while there is room
            if (!known && classful_prefix(s) == classful_prefix(reg_router_lan))
            begin
                if (append_entry(s, sp, PORT_W'(DYNAMIC_PORT_BASE + dyn_created)))
                begin
                    dyn_created++;
                    r.added = 1'b1;
                end
            end
            // First matching entry wins; a LAN address hit with another port
            // is passed over without an inbound test
            r.action = ACT_DROP;
            hit = 1'b0;
            for (int i = 0; i < tbl_used && !hit; i++)
            begin
                if (tbl_lan_addr[i] == s)
                begin
                    if (tbl_priv_port[i] == sp)
                    begin
                        s = reg_wan_addr;
                        sp = tbl_pub_port[i];
                        r.action = ACT_OUT;
                        hit = 1'b1;
                    end
                end
                else if (d == reg_wan_addr && dp == tbl_pub_port[i])
                begin
                    d = tbl_lan_addr[i];
                    dp = tbl_priv_port[i];
                    r.action = ACT_IN;
                    hit = 1'b1;
                end
            end
        end
        r.src = s;
        r.dst = d;
        r.sport = sp;
        r.dport = dp;
        r.ttl = it.ttl_in - 8'd1;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Scoreboard: check results, track config writes, predict accepted items
    always @(posedge clk)
    begin : xlat_monitor
        result_t    exp_r;
        napt_item_t acc;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result with none outstanding, expected nothing actual action %0h",
                             $time, rsp.action);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    compare_field("action", 32'(exp_r.action), 32'(rsp.action));
                    compare_field("out_source_address", exp_r.src, rsp.out_source_address);
                    compare_field("out_dest_address", exp_r.dst, rsp.out_dest_address);
                    compare_field("out_source_port", 32'(exp_r.sport), 32'(rsp.out_source_port));
                    compare_field("out_dest_port", 32'(exp_r.dport), 32'(rsp.out_dest_port));
                    compare_field("ttl_out", 32'(exp_r.ttl), 32'(rsp.ttl_out));
                    compare_field("dynamic_added", 32'(exp_r.added), 32'(rsp.dynamic_added));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_WAN_ADDRESS)
                    reg_wan_addr = cfg.data;
                else if (cfg.index == CFG_ROUTER_LAN_ADDRESS)
                    reg_router_lan = cfg.data;
            end
            if (req.valid && req.ready)
            begin
                acc.opcode = req.opcode;
                acc.protocol = req.protocol;
                acc.ttl_in = req.ttl_in;
                acc.src_addr = req.source_address;
                acc.dst_addr = req.dest_address;
                acc.src_port = req.source_port;
                acc.dst_port = req.dest_port;
                acc.ld_addr = req.load_lan_address;
                acc.ld_priv_port = req.load_lan_port;
                acc.ld_pub_port = req.load_wan_port;
                pending_results.push_back(predict_translation(acc));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb_napt_translation_table_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result backpressure: a randomly chosen mode held for a random span
    initial
    begin : rsp_stall_gen
        int mode;
        int span;
        int tick;
        rsp.ready <= 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(8, 60);
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 1) == 0);
                    2: rsp.ready <= ($urandom_range(0, 3) == 0);
                    3: rsp.ready <= (tick % 5) != 0;
                    default: rsp.ready <= (k == span - 1);
                endcase
            end
        end
    end

    // Stimulus helpers
    function automatic napt_item_t random_item();
        napt_item_t it;
        it.opcode = 1'($urandom_range(0, 1));
        it.protocol = PROTO_W'($urandom);
        it.ttl_in = TTL_W'($urandom);
        it.src_addr = $urandom;
        it.dst_addr = $urandom;
        it.src_port = PORT_W'($urandom);
        it.dst_port = PORT_W'($urandom);
        it.ld_addr = $urandom;
        it.ld_priv_port = PORT_W'($urandom);
        it.ld_pub_port = PORT_W'($urandom);
        return it;
    endfunction

    function automatic napt_item_t make_packet(input logic [PROTO_W-1:0] proto,
                                               input logic [TTL_W-1:0] ttl,
                                               input logic [ADDR_W-1:0] src,
                                               input logic [PORT_W-1:0] sport,
                                               input logic [ADDR_W-1:0] dst,
                                               input logic [PORT_W-1:0] dport);
        napt_item_t it;
        it = random_item();
        it.opcode = OP_PACKET;
        it.protocol = proto;
        it.ttl_in = ttl;
        it.src_addr = src;
        it.src_port = sport;
        it.dst_addr = dst;
        it.dst_port = dport;
        return it;
    endfunction

    function automatic napt_item_t make_load(input logic [ADDR_W-1:0] a,
                                             input logic [PORT_W-1:0] lp,
                                             input logic [PORT_W-1:0] wp);
        napt_item_t it;
        it = random_item();
        it.opcode = OP_LOAD;
        it.ld_addr = a;
        it.ld_priv_port = lp;
        it.ld_pub_port = wp;
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_in_net(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] a;
        a = $urandom;
        if (!base[31])
            a[31:24] = base[31:24];
        else if (base[31:30] == 2'b10)
            a[31:16] = base[31:16];
        else if (base[31:29] == 3'b110)
            a[31:8] = base[31:8];
        else
            a = base;
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_off_net(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] a;
        a = $urandom;
        while (classful_prefix(a) == classful_prefix(base))
            a = $urandom;
        return a;
    endfunction

    function automatic logic [PROTO_W-1:0] tcp_or_udp();
        return ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
    endfunction

    // One request transfer; sender runs in bursts with random gaps
    task automatic send_item(input napt_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.opcode <= it.opcode;
        req.protocol <= it.protocol;
        req.ttl_in <= it.ttl_in;
        req.source_address <= it.src_addr;
        req.dest_address <= it.dst_addr;
        req.source_port <= it.src_port;
        req.dest_port <= it.dst_port;
        req.load_lan_address <= it.ld_addr;
        req.load_lan_port <= it.ld_priv_port;
        req.load_wan_port <= it.ld_pub_port;
        req.valid <= 1'b1;
        do @(posedge clk); while (!req.ready);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] wan, input logic [ADDR_W-1:0] lan);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.index <= CFG_WAN_ADDRESS;
        cfg.data <= wan;
        do @(posedge clk); while (!cfg.ready);
        cfg.index <= CFG_ROUTER_LAN_ADDRESS;
        cfg.data <= lan;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Registers at their reset values: LAN side is network 0, WAN address 0
    task automatic test_reset_values();
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h0A010101, 16'd1000, 32'h00000005, 16'd80));
        send_item(make_packet(PROTO_UDP, 8'd64, 32'h00010203, 16'd100, 32'h08080808, 16'd53));
        send_item(make_packet(PROTO_UDP, 8'd64, 32'h08080808, 16'd53, 32'h00000000,
                              16'(DYNAMIC_PORT_BASE)));
    endtask

    // Directed cases: field extremes, every action but a full table, walk corner cases
    task automatic test_directed();
        logic [ADDR_W-1:0] wan;
        wan = 32'hCB007105;
        write_config(wan, 32'hC0A80101);
        // static entries, including all-ones and all-zeros
        send_item(make_load(32'hC0A8010A, 16'd80, 16'd8080));
        send_item(make_load(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_load(32'h00000000, 16'h0000, 16'h0000));
        // TTL boundaries
        send_item(make_packet(PROTO_TCP, 8'd0, 32'hC0A8010A, 16'd80, 32'h08080808, 16'd53));
        send_item(make_packet(PROTO_UDP, 8'd1, 32'hC0A8010A, 16'd80, 32'h08080808, 16'd53));
        send_item(make_packet(8'd1, 8'd2, 32'hC0A8010A, 16'd80, 32'h08080808, 16'd53));
        send_item(make_packet(8'hFF, 8'hFF, 32'h01020304, 16'hFFFF, 32'hFFFFFFFF, 16'h0000));
        // same classful network passes
        send_item(make_packet(PROTO_TCP, 8'd64, 32'hC0A8010A, 16'd80, 32'hC0A80114, 16'd22));
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h00000000, 16'd0, 32'h00000000, 16'd0));
        send_item(make_packet(PROTO_UDP, 8'd64, 32'hAC100505, 16'd9, 32'hAC10C801, 16'd9));
        // outbound on a static entry, then a new flow creating a dynamic one
        send_item(make_packet(PROTO_TCP, 8'd64, 32'hC0A8010A, 16'd80, 32'h08080808, 16'd53));
        send_item(make_packet(PROTO_UDP, 8'd64, 32'hC0A80121, 16'd5000, 32'h08080808, 16'd53));
        // inbound to static and dynamic entries, and an inbound miss
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h08080808, 16'd53, wan, 16'd8080));
        send_item(make_packet(PROTO_UDP, 8'd64, 32'h08080808, 16'd53, wan,
                              16'(DYNAMIC_PORT_BASE + 1)));
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h08080808, 16'd53, wan, 16'd1234));
        // unknown non-LAN source is dropped without a new entry
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h0A000001, 16'd1, 32'h08080808, 16'd2));
        // LAN address known on another port: new dynamic entry for this port
        send_item(make_packet(PROTO_TCP, 8'd64, 32'hC0A8010A, 16'd81, wan, 16'd8080));
        // address match with wrong port hides the inbound match on that same entry
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h00000000, 16'd7, wan, 16'd0));
        // all-ones header hits the all-ones entry
        send_item(make_packet(PROTO_UDP, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 32'h00000000, 16'h0000));
        send_item(make_packet(PROTO_UDP, 8'd64, 32'hAC100505, 16'd9, 32'hAC110001, 16'd9));
        send_item(make_packet(PROTO_TCP, 8'd64, 32'hE0000001, 16'd9, 32'hE0000002, 16'd9));
    endtask

    // Mostly well-formed flows against the current table, some noise
    task automatic run_random_phase(input logic [ADDR_W-1:0] wan, input logic [ADDR_W-1:0] lan,
                                    input int count);
        napt_item_t it;
        int         kind;
        int         pick;
        write_config(wan, lan);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2 || $urandom_range(0, 59) == 0)
                wait_drained();
            it = random_item();
            kind = $urandom_range(0, 99);
            pick = (tbl_used > 0) ? $urandom_range(0, tbl_used - 1) : -1;
            if (kind >= 5)
            begin
                it.opcode = OP_PACKET;
                it.ttl_in = TTL_W'($urandom_range(2, 255));
                it.protocol = tcp_or_udp();
            end
            if (pick < 0 && kind >= 50)
                kind = 25;
            if (kind < 5)
                ;
            else if (kind < 10)
            begin
                it.opcode = OP_LOAD;
                if ($urandom_range(0, 1) == 0)
                    it.ld_addr = addr_in_net(lan);
            end
            else if (kind < 15)
                it.ttl_in = TTL_W'($urandom_range(0, 1));
            else if (kind < 20)
            begin
                do it.protocol = PROTO_W'($urandom);
                while (it.protocol == PROTO_TCP || it.protocol == PROTO_UDP);
            end
            else if (kind < 25)
                it.dst_addr = addr_in_net(it.src_addr);
            else if (kind < 50)
            begin
                it.src_addr = addr_in_net(lan);
                it.dst_addr = addr_off_net(it.src_addr);
            end
            else if (kind < 70)
            begin
                it.src_addr = tbl_lan_addr[pick];
                it.src_port = tbl_priv_port[pick];
                it.dst_addr = addr_off_net(it.src_addr);
            end
            else if (kind < 90)
            begin
                it.dst_addr = wan;
                it.dst_port = tbl_pub_port[pick];
                it.src_addr = addr_off_net(wan);
            end
            else
            begin
                it.dst_addr = wan;
                it.src_addr = addr_off_net(wan);
            end
            send_item(it);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(32'h64400001, 32'h0A000001, 150);
        run_random_phase($urandom, 32'hAC100001, 120);
        run_random_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 90);
        run_random_phase(32'h00000000, 32'hC0A8FE01, 90);
    endtask

    // Loads past capacity, then lookups on a full table
    task automatic test_table_full();
        logic [ADDR_W-1:0] wan;
        logic [ADDR_W-1:0] lan;
        int                spare;
        wan = 32'h01020304;
        lan = 32'hC0A80001;
        write_config(wan, lan);
        spare = TABLE_DEPTH - tbl_used;
        repeat (spare + 3)
            send_item(make_load(addr_in_net(lan), PORT_W'($urandom), PORT_W'($urandom)));
        send_item(make_packet(PROTO_UDP, 8'd64, addr_in_net(lan), PORT_W'($urandom),
                              32'h08080808, 16'd53));
        send_item(make_packet(PROTO_TCP, 8'd64, 32'h08080808, 16'd53, wan, tbl_pub_port[0]));
        send_item(make_packet(PROTO_TCP, 8'd64, tbl_lan_addr[TABLE_DEPTH - 1],
                              tbl_priv_port[TABLE_DEPTH - 1], 32'h08080808, 16'd80));
    endtask

    initial
    begin
        rst_n = 1'b0;
        err_count = 0;
        burst_left = 0;
        tbl_used = 0;
        dyn_created = 0;
        reg_wan_addr = '0;
        reg_router_lan = '0;
        req.valid <= 1'b0;
        req.opcode <= OP_LOAD;
        req.protocol <= '0;
        req.ttl_in <= '0;
        req.source_address <= '0;
        req.dest_address <= '0;
        req.source_port <= '0;
        req.dest_port <= '0;
        req.load_lan_address <= '0;
        req.load_lan_port <= '0;
        req.load_wan_port <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_WAN_ADDRESS;
        cfg.data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_random_traffic();
        test_table_full();

        // Drain and let the block settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_napt_translation_table_top: clean");
        else
            $display("tb_napt_translation_table_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/napt_pkg.sv
rtl/core/napt_if.sv
rtl/core/napt_ram.sv
rtl/core/napt_front.sv
rtl/core/napt_queue.sv
rtl/core/napt_back.sv
rtl/core/napt_translation_table_top.sv
tb/tb_napt_translation_table_top.sv
